>>> src/utf8_validate_sanitize_assert.svh
// assertion macros for the utf8 validator
`ifndef UTF8_VALIDATE_SANITIZE_ASSERT_SVH
`define UTF8_VALIDATE_SANITIZE_ASSERT_SVH

`ifndef SYNTHESIS

`define UVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define UVS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UVS_ASSERT(lbl, prop, msg)

`define UVS_ASSERT_RST(lbl, prop, msg)

`endif

`endif

>>> src/uvs_pkg.sv
`default_nettype none

package uvs_pkg;

  localparam int unsigned DROP_COUNT_BITS_DEF = 32;
  localparam int unsigned SHOWN_BITS          = 32;

  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_MIN    = 8'hC2;
  localparam logic [7:0] LEAD2_MAX   = 8'hDF;
  localparam logic [7:0] LEAD3_MAX   = 8'hEF;
  localparam logic [7:0] LEAD_MAX    = 8'hF4;
  localparam logic [7:0] LEAD_E0     = 8'hE0;
  localparam logic [7:0] LEAD_ED     = 8'hED;
  localparam logic [7:0] LEAD_F0     = 8'hF0;
  localparam logic [7:0] LEAD_F4     = 8'hF4;
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] CONT_E0_MIN = 8'hA0;
  localparam logic [7:0] CONT_ED_MAX = 8'h9F;
  localparam logic [7:0] CONT_F0_MIN = 8'h90;
  localparam logic [7:0] CONT_F4_MAX = 8'h8F;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       string_end;
  } uvs_in_t;

  typedef struct packed {
    logic [31:0] kept_bytes;
    logic [2:0]  kept_count;
    logic [2:0]  dropped_now;
    logic        string_done;
    logic        string_valid;
    logic [31:0] dropped_total;
  } uvs_out_t;

endpackage

`default_nettype wire

>>> src/uvs_if.sv
`default_nettype none

interface uvs_in_if;
  logic             valid;
  logic             ready;
  uvs_pkg::uvs_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface uvs_out_if;
  logic              valid;
  logic              ready;
  uvs_pkg::uvs_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/utf8_validate_sanitize.sv
// utf8_validate_sanitize: checks a byte stream for well-formed utf-8
// in_ch carries one byte per item with byte_present and string_end flags;
// an item with byte_present low and string_end high closes a string
// out_ch returns exactly one result item per input item, in order: the
// bytes passed on (a whole sequence or one ascii byte), bytes dropped by
// this item, a string close flag with a valid flag, and the running
// dropped total of the string, saturating at all ones
// the result register is loaded on input accept and is valid in the next cycle
// throughput: one item per cycle while out_ch.ready is high; the
// judgement of a byte against the buffered sequence is a single pass
// between the pending-sequence state and the result register
// in_ch.ready stays high while the result register is empty or being
// taken, so a stalled receiver holds the result and stops input after one
// item; nothing is lost while out_ch.ready is low
// reset (rst, synchronous) empties the result register, drops any
// buffered sequence and clears the dropped total
`default_nettype none

`include "utf8_validate_sanitize_assert.svh"

module utf8_validate_sanitize #(
  parameter int unsigned DROP_COUNT_BITS = uvs_pkg::DROP_COUNT_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  uvs_in_if.sink     in_ch,
  uvs_out_if.source  out_ch
);

  logic [7:0]                 pending_bytes [3];
  logic [1:0]                 pending_count;
  logic [2:0]                 needed_length;
  logic [DROP_COUNT_BITS-1:0] drop_counter;
  logic                       out_valid;
  uvs_pkg::uvs_out_t          out_data;

  logic [7:0]                 pending_bytes_next [3];
  logic [1:0]                 pending_count_next;
  logic [2:0]                 needed_length_next;
  logic [DROP_COUNT_BITS-1:0] drop_counter_next;
  uvs_pkg::uvs_out_t          out_data_next;

  logic                       accept;
  logic [7:0]                 b;
  logic                       is_ascii;
  logic                       is_bad;
  logic [2:0]                 lead_len;
  logic [7:0]                 cont_lo;
  logic [7:0]                 cont_hi;
  logic                       cont_ok;
  logic [31:0]                kept;
  logic [2:0]                 kcount;
  logic [2:0]                 dropped;
  logic [DROP_COUNT_BITS:0]   cnt_sum;
  logic [DROP_COUNT_BITS-1:0] cnt_sat;
  logic [31:0]                shown;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  assign b        = in_ch.data.byte_value;
  assign is_ascii = b < uvs_pkg::ASCII_LIMIT;
  assign is_bad   = (b < uvs_pkg::LEAD_MIN) || (b > uvs_pkg::LEAD_MAX);
  assign lead_len = (b <= uvs_pkg::LEAD2_MAX) ? 3'd2 :
                    (b <= uvs_pkg::LEAD3_MAX) ? 3'd3 : 3'd4;

  // second byte range depends on the leader
  always_comb begin
    cont_lo = uvs_pkg::CONT_MIN;
    cont_hi = uvs_pkg::CONT_MAX;
    if (pending_count == 2'd1) begin
      if (pending_bytes[0] == uvs_pkg::LEAD_E0) cont_lo = uvs_pkg::CONT_E0_MIN;
      if (pending_bytes[0] == uvs_pkg::LEAD_ED) cont_hi = uvs_pkg::CONT_ED_MAX;
      if (pending_bytes[0] == uvs_pkg::LEAD_F0) cont_lo = uvs_pkg::CONT_F0_MIN;
      if (pending_bytes[0] == uvs_pkg::LEAD_F4) cont_hi = uvs_pkg::CONT_F4_MAX;
    end
  end

  assign cont_ok = (pending_count != 2'd0) && (b >= cont_lo) && (b <= cont_hi);

  always_comb begin
    pending_bytes_next = pending_bytes;
    pending_count_next = pending_count;
    needed_length_next = needed_length;
    kept               = 32'd0;
    kcount             = 3'd0;
    dropped            = 3'd0;
    if (in_ch.data.byte_present) begin
      if (cont_ok) begin
        if (({1'b0, pending_count} + 3'd1) >= needed_length) begin
          case (pending_count)
            2'd1: kept = {16'd0, b, pending_bytes[0]};
            2'd2: kept = {8'd0, b, pending_bytes[1], pending_bytes[0]};
            2'd3: kept = {b, pending_bytes[2], pending_bytes[1], pending_bytes[0]};
            default: kept = 32'd0;
          endcase
          kcount             = {1'b0, pending_count} + 3'd1;
          pending_count_next = 2'd0;
          needed_length_next = 3'd0;
        end else begin
          case (pending_count)
            2'd1: pending_bytes_next[1] = b;
            2'd2: pending_bytes_next[2] = b;
            default: pending_bytes_next = pending_bytes;
          endcase
          pending_count_next = pending_count + 2'd1;
        end
      end else begin
        // buffered bytes go, byte is judged again as a leader
        dropped            = {1'b0, pending_count};
        pending_count_next = 2'd0;
        needed_length_next = 3'd0;
        if (is_ascii) begin
          kept   = {24'd0, b};
          kcount = 3'd1;
        end else if (is_bad) begin
          dropped = dropped + 3'd1;
        end else begin
          pending_bytes_next[0] = b;
          pending_count_next    = 2'd1;
          needed_length_next    = lead_len;
        end
      end
    end
    if (in_ch.data.string_end) begin
      dropped            = dropped + {1'b0, pending_count_next};
      pending_count_next = 2'd0;
      needed_length_next = 3'd0;
    end
  end

  assign cnt_sum = {1'b0, drop_counter} + (DROP_COUNT_BITS + 1)'(dropped);
  assign cnt_sat = cnt_sum[DROP_COUNT_BITS] ? '1 : cnt_sum[DROP_COUNT_BITS-1:0];

  if (DROP_COUNT_BITS > uvs_pkg::SHOWN_BITS) begin : g_wide
    assign shown = (|cnt_sat[DROP_COUNT_BITS-1:uvs_pkg::SHOWN_BITS]) ? '1 :
                   cnt_sat[uvs_pkg::SHOWN_BITS-1:0];
  end else begin : g_narrow
    assign shown = 32'(cnt_sat);
  end

  assign drop_counter_next = in_ch.data.string_end ? '0 : cnt_sat;

  always_comb begin
    out_data_next.kept_bytes    = kept;
    out_data_next.kept_count    = kcount;
    out_data_next.dropped_now   = dropped;
    out_data_next.string_done   = in_ch.data.string_end;
    out_data_next.string_valid  = in_ch.data.string_end && (cnt_sat == '0);
    out_data_next.dropped_total = shown;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= 2'd0;
      needed_length <= 3'd0;
      drop_counter  <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        pending_count <= pending_count_next;
        needed_length <= needed_length_next;
        drop_counter  <= drop_counter_next;
        out_valid     <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pending_bytes <= pending_bytes_next;
      out_data      <= out_data_next;
    end
  end

  `UVS_ASSERT(a_len_match, (pending_count == 2'd0) == (needed_length == 3'd0), "pending count and length disagree")
  `UVS_ASSERT(a_three_needs_four, (pending_count == 2'd3) |-> (needed_length == 3'd4), "three bytes buffered for a short sequence")
  `UVS_ASSERT(a_close_clears, (accept && in_ch.data.string_end) |=> ((pending_count == 2'd0) && (drop_counter == '0)), "string close left state behind")
  `UVS_ASSERT_RST(a_rst_empty, rst |=> !out_valid, "result register not empty after reset")

endmodule

`default_nettype wire

>>> tb/tb_utf8_validate_sanitize.sv
module tb_utf8_validate_sanitize;
  timeunit 1ns;
  timeprecision 1ps;

  // counter width as built
  localparam int unsigned CNT_BITS    = uvs_pkg::DROP_COUNT_BITS_DEF;
  localparam logic [63:0] DROP_MAX    = (CNT_BITS >= 64) ? '1 : ((64'd1 << CNT_BITS) - 64'd1);
  localparam int          CYCLE_LIMIT = 500000;
  localparam int          HOLD_CYCLES = 300;

  typedef enum logic [1:0] {LEAD_KEEP, LEAD_HOLD, LEAD_DROP} lead_verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  utf8_validate_sanitize #(
    .DROP_COUNT_BITS(CNT_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state of the sanitizer
  logic [7:0]  held_bytes [3] = '{8'h00, 8'h00, 8'h00};
  logic [1:0]  held_count   = '0;
  logic [2:0]  seq_length   = '0;
  logic [63:0] string_drops = '0;

  uvs_pkg::uvs_out_t sanitized_fifo [$];
  logic [7:0]        str_bytes [$];

  int  mismatch_count = 0;
  int  items_sent     = 0;
  int  results_seen   = 0;
  int  strings_closed = 0;
  int  cycle_count    = 0;
  int  stall_left     = 0;
  bit  no_idle        = 1'b0;
  bit  hold_request   = 1'b0;

  function automatic lead_verdict_t judge_leader(logic [7:0] b);
    if (b < uvs_pkg::ASCII_LIMIT) return LEAD_KEEP;
    if (b < uvs_pkg::LEAD_MIN || b > uvs_pkg::LEAD_MAX) return LEAD_DROP;
    seq_length    = (b <= uvs_pkg::LEAD2_MAX) ? 3'd2 : (b <= uvs_pkg::LEAD3_MAX) ? 3'd3 : 3'd4;
    held_bytes[0] = b;
    held_count    = 2'd1;
    return LEAD_HOLD;
  endfunction

  function automatic bit fits_sequence(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = uvs_pkg::CONT_MIN;
    hi = uvs_pkg::CONT_MAX;
    if (held_count == 2'd1) begin
      if (held_bytes[0] == uvs_pkg::LEAD_E0) lo = uvs_pkg::CONT_E0_MIN;
      if (held_bytes[0] == uvs_pkg::LEAD_ED) hi = uvs_pkg::CONT_ED_MAX;
      if (held_bytes[0] == uvs_pkg::LEAD_F0) lo = uvs_pkg::CONT_F0_MIN;
      if (held_bytes[0] == uvs_pkg::LEAD_F4) hi = uvs_pkg::CONT_F4_MAX;
    end
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic uvs_pkg::uvs_out_t sanitize_step(uvs_pkg::uvs_in_t it);
    uvs_pkg::uvs_out_t res;
    logic [7:0]        b;
    logic [2:0]        dropped;
    lead_verdict_t     v;
    int                k;
    res     = '0;
    b       = it.byte_value;
    dropped = '0;
    if (it.byte_present) begin
      if (held_count == 2'd0) begin
        v = judge_leader(b);
        if (v == LEAD_KEEP) begin
          res.kept_bytes = {24'h0, b};
          res.kept_count = 3'd1;
        end else if (v == LEAD_DROP) begin
          dropped = 3'd1;
        end
      end else if (fits_sequence(b)) begin
        k = held_count;
        if (k + 1 >= seq_length) begin
          for (int i = 0; i < k; i++) res.kept_bytes[8*i +: 8] = held_bytes[i];
          res.kept_bytes[8*k +: 8] = b;
          res.kept_count = 3'(k + 1);
          held_count = '0;
          seq_length = '0;
        end else begin
          held_bytes[k] = b;
          held_count    = 2'(k + 1);
        end
      end else begin
        dropped    = 3'(held_count);
        held_count = '0;
        seq_length = '0;
        v = judge_leader(b);
        if (v == LEAD_KEEP) begin
          res.kept_bytes = {24'h0, b};
          res.kept_count = 3'd1;
        end else if (v == LEAD_DROP) begin
          dropped = dropped + 3'd1;
        end
      end
    end
    if (it.string_end) begin
      dropped         = dropped + 3'(held_count);
      held_count      = '0;
      seq_length      = '0;
      res.string_done = 1'b1;
    end
    if (DROP_MAX - string_drops < 64'(dropped)) string_drops = DROP_MAX;
    else string_drops = string_drops + 64'(dropped);
    res.dropped_now   = dropped;
    res.dropped_total = (string_drops > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : string_drops[31:0];
    if (res.string_done) begin
      res.string_valid = (string_drops == 0);
      string_drops     = '0;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h want %h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // starts and ends at a falling edge
  task automatic send_item(input logic [7:0] value, input logic present, input logic last);
    uvs_pkg::uvs_in_t it;
    int               gap;
    it.byte_value   = value;
    it.byte_present = present;
    it.string_end   = last;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      in_ch.data  = 10'($urandom_range(0, 1023));
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.data  = it;
    do @(posedge clk); while (!in_ch.ready);
    sanitized_fifo.push_back(sanitize_step(it));
    items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] second_byte(logic [7:0] lead);
    int lo;
    int hi;
    lo = uvs_pkg::CONT_MIN;
    hi = uvs_pkg::CONT_MAX;
    if (lead == uvs_pkg::LEAD_E0) lo = uvs_pkg::CONT_E0_MIN;
    if (lead == uvs_pkg::LEAD_ED) hi = uvs_pkg::CONT_ED_MAX;
    if (lead == uvs_pkg::LEAD_F0) lo = uvs_pkg::CONT_F0_MIN;
    if (lead == uvs_pkg::LEAD_F4) hi = uvs_pkg::CONT_F4_MAX;
    return 8'($urandom_range(hi, lo));
  endfunction

  // appends one well-formed character, returns its length
  function automatic int add_char();
    logic [7:0] lead;
    int         len;
    len = 1;
    lead = '0;
    case ($urandom_range(0, 3))
      0: str_bytes.push_back(8'($urandom_range(0, 127)));
      1: begin
        lead = 8'($urandom_range(uvs_pkg::LEAD_MIN, uvs_pkg::LEAD2_MAX));
        len  = 2;
      end
      2: begin
        case ($urandom_range(0, 2))
          0: lead = uvs_pkg::LEAD_E0;
          1: lead = uvs_pkg::LEAD_ED;
          default: lead = 8'($urandom_range(8'hE1, uvs_pkg::LEAD3_MAX));
        endcase
        len = 3;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: lead = uvs_pkg::LEAD_F0;
          1: lead = uvs_pkg::LEAD_F4;
          default: lead = 8'($urandom_range(8'hF1, 8'hF3));
        endcase
        len = 4;
      end
    endcase
    if (len > 1) begin
      str_bytes.push_back(lead);
      str_bytes.push_back(second_byte(lead));
      for (int i = 2; i < len; i++)
        str_bytes.push_back(8'($urandom_range(uvs_pkg::CONT_MIN, uvs_pkg::CONT_MAX)));
    end
    return len;
  endfunction

  function automatic void add_noise();
    int n;
    case ($urandom_range(0, 3))
      0: str_bytes.push_back(8'($urandom_range(0, 255)));
      1: begin
        n = add_char();
        if (n > 1) void'(str_bytes.pop_back());
      end
      2: begin
        n = add_char();
        if (n > 1) str_bytes[str_bytes.size() - 1] = 8'($urandom_range(0, 255));
      end
      default: begin
        case ($urandom_range(0, 3))
          0: str_bytes.push_back(uvs_pkg::LEAD_E0);
          1: str_bytes.push_back(uvs_pkg::LEAD_ED);
          2: str_bytes.push_back(uvs_pkg::LEAD_F0);
          default: str_bytes.push_back(uvs_pkg::LEAD_F4);
        endcase
        str_bytes.push_back(8'($urandom_range(uvs_pkg::CONT_MIN, uvs_pkg::CONT_MAX)));
      end
    endcase
  endfunction

  task automatic send_string();
    bit marker_end;
    int last;
    marker_end = (str_bytes.size() == 0) || ($urandom_range(0, 2) == 0);
    last = str_bytes.size() - 1;
    foreach (str_bytes[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(str_bytes[i], 1'b1, (i == last) && !marker_end);
    end
    if (marker_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    str_bytes.delete();
  endtask

  task automatic test_random_strings(input int n_items);
    int start;
    int units;
    start = items_sent;
    while (items_sent - start < n_items) begin
      units = $urandom_range(0, 10);
      repeat (units) begin
        if ($urandom_range(0, 99) < 75) void'(add_char());
        else add_noise();
      end
      send_string();
    end
  endtask

  task automatic test_leader_extremes();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hC1, 1'b1, 1'b0);
    send_item(8'hF5, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
  endtask

  task automatic test_second_byte_bounds();
    str_bytes = {8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF,
                 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    foreach (str_bytes[i]) send_item(str_bytes[i], 1'b1, 1'b0);
    send_item(8'hC2, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    // second byte just outside the leader's range
    str_bytes = {8'hE0, 8'h9F, 8'hF4, 8'h90};
    foreach (str_bytes[i]) send_item(str_bytes[i], 1'b1, i == 3);
    str_bytes.delete();
  endtask

  task automatic test_string_end_cases();
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hC2, 1'b1, 1'b1);
    // three buffered bytes then an invalid leader drops four
    send_item(8'hF0, 1'b1, 1'b0);
    send_item(8'h90, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hE1, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    send_item(8'hE1, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_long_drop_run();
    repeat (300) begin
      if ($urandom_range(0, 1) == 0) send_item(8'($urandom_range(8'h80, 8'hC1)), 1'b1, 1'b0);
      else send_item(8'($urandom_range(8'hF5, 8'hFF)), 1'b1, 1'b0);
    end
    send_item(8'h41, 1'b1, 1'b1);
    send_item(8'h42, 1'b1, 1'b1);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_strings(80);
    no_idle = 1'b0;
  endtask

  task automatic test_receiver_hold();
    no_idle      = 1'b1;
    hold_request = 1'b1;
    test_random_strings(40);
    no_idle      = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    test_leader_extremes();
    test_second_byte_bounds();
    test_string_end_cases();
    test_long_drop_run();
    test_random_strings(320);
    test_back_to_back();
    test_receiver_hold();
    in_ch.valid = 1'b0;
    while (sanitized_fifo.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("sent %0d items, checked %0d results over %0d closed strings", items_sent,
             results_seen, strings_closed);
    $display("directed leader bounds, string ends, long drop runs, random strings, stalls");
    if (mismatch_count == 0) begin
      $display("utf8_validate_sanitize: match");
    end else begin
      $display("utf8_validate_sanitize: mismatch");
    end
    $finish;
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if (!no_idle && $urandom_range(0, 2) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    uvs_pkg::uvs_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.data.string_done) strings_closed++;
      if (sanitized_fifo.size() == 0) begin
        report_mismatch("result with nothing predicted", 32'h0, 32'h0);
      end else begin
        want = sanitized_fifo.pop_front();
        if (out_ch.data.kept_bytes !== want.kept_bytes)
          report_mismatch("kept_bytes", out_ch.data.kept_bytes, want.kept_bytes);
        if (out_ch.data.kept_count !== want.kept_count)
          report_mismatch("kept_count", 32'(out_ch.data.kept_count), 32'(want.kept_count));
        if (out_ch.data.dropped_now !== want.dropped_now)
          report_mismatch("dropped_now", 32'(out_ch.data.dropped_now), 32'(want.dropped_now));
        if (out_ch.data.string_done !== want.string_done)
          report_mismatch("string_done", 32'(out_ch.data.string_done), 32'(want.string_done));
        if (out_ch.data.string_valid !== want.string_valid)
          report_mismatch("string_valid", 32'(out_ch.data.string_valid),
                          32'(want.string_valid));
        if (out_ch.data.dropped_total !== want.dropped_total)
          report_mismatch("dropped_total", out_ch.data.dropped_total, want.dropped_total);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("utf8_validate_sanitize: mismatch");
      $finish;
    end
  end

endmodule
